/* hw/rtl/tnr_pkg.sv */
// Shared types, byte codes and result-list helpers for the telnet receive negotiator.
package tnr_pkg;

    localparam int MAX_RES   = 8;
    localparam int RES_IW    = $clog2(MAX_RES);
    localparam int RES_CW    = $clog2(MAX_RES + 1);
    localparam int Q_DEPTH   = 16;

    // telnet command bytes
    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_GA   = 8'd249;
    localparam logic [7:0] B_EL   = 8'd248;
    localparam logic [7:0] B_EC   = 8'd247;
    localparam logic [7:0] B_AYT  = 8'd246;
    localparam logic [7:0] B_AO   = 8'd245;

    localparam logic [7:0] OPT_ECHO = 8'd1;
    localparam logic [7:0] OPT_SGA  = 8'd3;
    localparam logic [7:0] OPT_TM   = 8'd6;

    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_CSI = 8'h9B;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_B   = 8'h42;
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [7:0] CH_D   = 8'h44;

    // parser modes
    localparam logic [3:0] M_DATA = 4'd0;
    localparam logic [3:0] M_IAC  = 4'd1;
    localparam logic [3:0] M_WILL = 4'd2;
    localparam logic [3:0] M_WONT = 4'd3;
    localparam logic [3:0] M_DO   = 4'd4;
    localparam logic [3:0] M_DONT = 4'd5;
    localparam logic [3:0] M_CR   = 4'd6;
    localparam logic [3:0] M_ESC  = 4'd7;
    localparam logic [3:0] M_CSI  = 4'd8;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_CMD  = 2'd1;
    localparam logic [1:0] KIND_EVT  = 2'd2;

    // event codes
    localparam logic [7:0] EV_ABORT      = 8'd0;
    localparam logic [7:0] EV_AYT        = 8'd1;
    localparam logic [7:0] EV_ERASE_CHAR = 8'd2;
    localparam logic [7:0] EV_ERASE_LINE = 8'd3;
    localparam logic [7:0] EV_UNBLOCK    = 8'd4;
    localparam logic [7:0] EV_ACK        = 8'd5;
    localparam logic [7:0] EV_UP         = 8'd6;
    localparam logic [7:0] EV_DOWN       = 8'd7;
    localparam logic [7:0] EV_RIGHT      = 8'd8;
    localparam logic [7:0] EV_LEFT       = 8'd9;
    localparam logic [7:0] EV_REDRAW     = 8'd10;
    localparam logic [7:0] EV_BELL       = 8'd11;
    localparam logic [7:0] EV_ECHO_DONE  = 8'd12;
    localparam logic [7:0] EV_LSGA_DONE  = 8'd13;
    localparam logic [7:0] EV_RSGA_DONE  = 8'd14;

    // option bit positions: bit 0 WILL side, bit 1 DO side
    localparam logic [1:0] WILL_BIT = 2'b01;
    localparam logic [1:0] DO_BIT   = 2'b10;

    localparam logic [2:0] DONE_ECHO = 3'b001;
    localparam logic [2:0] DONE_LSGA = 3'b010;
    localparam logic [2:0] DONE_RSGA = 3'b100;

    typedef struct packed {
        logic [3:0] mode;
        logic [1:0] echo;
        logic [1:0] lsga;
        logic [1:0] rsga;
        logic [1:0] marks;
        logic       ack_on;
        logic [2:0] done;
    } t_state;

    typedef struct packed {
        logic [RES_CW-1:0]             cnt;
        logic [MAX_RES-1:0][1:0]       kind;
        logic [MAX_RES-1:0][7:0]       pay;
    } t_res_list;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload;
        logic       last;
        logic       echo_active;
        logic       go_ahead_suppressed;
        logic       ack_enabled;
    } t_entry;

    typedef t_entry [MAX_RES-1:0] t_entry_set;

    function automatic t_res_list f_push(input t_res_list l, input logic [1:0] k,
                                         input logic [7:0] p);
        t_res_list r;
        r = l;
        if (r.cnt < RES_CW'(MAX_RES)) begin
            r.kind[r.cnt[RES_IW-1:0]] = k;
            r.pay[r.cnt[RES_IW-1:0]]  = p;
            r.cnt = r.cnt + RES_CW'(1);
        end
        return r;
    endfunction

    function automatic t_res_list f_send3(input t_res_list l, input logic [7:0] cmd,
                                          input logic [7:0] opt);
        t_res_list r;
        r = f_push(l, KIND_CMD, B_IAC);
        r = f_push(r, KIND_CMD, cmd);
        r = f_push(r, KIND_CMD, opt);
        return r;
    endfunction

endpackage

/* hw/rtl/tnr_decode.sv */
// Per-byte decode: next negotiation state and the ordered list of results.
module tnr_decode (
    input  logic [7:0]         i_byte,
    input  tnr_pkg::t_state    i_state,
    output tnr_pkg::t_state    o_state,
    output tnr_pkg::t_res_list o_list
);
    import tnr_pkg::*;

    always_comb begin
        t_state    st;
        t_res_list lst;
        logic      is_will;
        logic      is_do;
        st      = i_state;
        lst     = '0;
        is_will = (i_state.mode == M_WILL);
        is_do   = (i_state.mode == M_DO);

        unique case (i_state.mode)
            M_IAC: begin
                st.mode = M_DATA;
                unique case (i_byte)
                    B_AO:    lst = f_push(lst, KIND_EVT, EV_ABORT);
                    B_AYT:   lst = f_push(lst, KIND_EVT, EV_AYT);
                    B_EC:    lst = f_push(lst, KIND_EVT, EV_ERASE_CHAR);
                    B_EL:    lst = f_push(lst, KIND_EVT, EV_ERASE_LINE);
                    B_GA:    lst = f_push(lst, KIND_EVT, EV_UNBLOCK);
                    B_WILL:  st.mode = M_WILL;
                    B_WONT:  st.mode = M_WONT;
                    B_DO:    st.mode = M_DO;
                    B_DONT:  st.mode = M_DONT;
                    B_IAC:   lst = f_push(lst, KIND_DATA, B_IAC);
                    default: ;
                endcase
            end
            M_WILL, M_WONT: begin
                st.mode = M_DATA;
                if (i_byte == OPT_SGA) begin
                    if (is_will) begin
                        st.rsga = st.rsga | WILL_BIT;
                        if ((st.rsga & DO_BIT) == 2'b00) begin
                            st.rsga = st.rsga | DO_BIT;
                            lst = f_send3(lst, B_DO, OPT_SGA);
                            if (st.lsga == 2'b00) begin
                                lst = f_send3(lst, B_WILL, OPT_SGA);
                                st.lsga = st.lsga | WILL_BIT;
                            end
                            lst = f_push(lst, KIND_EVT, EV_UNBLOCK);
                        end
                    end else begin
                        st.rsga = st.rsga & ~WILL_BIT;
                        if ((st.rsga & DO_BIT) != 2'b00) begin
                            st.rsga = st.rsga & ~DO_BIT;
                            lst = f_send3(lst, B_DONT, OPT_SGA);
                        end
                    end
                    if ((st.done & DONE_RSGA) != 3'b000) begin
                        st.done = st.done & ~DONE_RSGA;
                        lst = f_push(lst, KIND_EVT, EV_RSGA_DONE);
                    end
                end else if (i_byte == OPT_TM) begin
                    if (st.marks != 2'd0) st.marks = st.marks - 2'd1;
                    if (st.ack_on) begin
                        lst = f_push(lst, KIND_EVT, EV_ACK);
                    end else if (st.echo == WILL_BIT && st.marks == 2'd0) begin
                        st.ack_on = 1'b1;
                    end
                end else if (is_will) begin
                    lst = f_send3(lst, B_DONT, i_byte);
                end
            end
            M_DO, M_DONT: begin
                st.mode = M_DATA;
                if (i_byte == OPT_ECHO) begin
                    if (is_do) begin
                        st.echo = st.echo | DO_BIT;
                        if ((st.echo & WILL_BIT) == 2'b00) begin
                            st.echo = st.echo | WILL_BIT;
                            lst = f_send3(lst, B_WILL, OPT_ECHO);
                        end
                    end else begin
                        st.echo = st.echo & ~DO_BIT;
                        if ((st.echo & WILL_BIT) != 2'b00) begin
                            st.echo = st.echo & ~WILL_BIT;
                            lst = f_send3(lst, B_WONT, OPT_ECHO);
                        end
                    end
                    if ((st.done & DONE_ECHO) != 3'b000) begin
                        st.done = st.done & ~DONE_ECHO;
                        lst = f_push(lst, KIND_EVT, EV_ECHO_DONE);
                    end
                end else if (i_byte == OPT_SGA) begin
                    if (is_do) begin
                        st.lsga = st.lsga | DO_BIT;
                        if ((st.lsga & WILL_BIT) == 2'b00) begin
                            st.lsga = st.lsga | WILL_BIT;
                            lst = f_send3(lst, B_WILL, OPT_SGA);
                            if (st.rsga == 2'b00) begin
                                lst = f_send3(lst, B_DO, OPT_SGA);
                                st.rsga = st.rsga | DO_BIT;
                            end
                            lst = f_push(lst, KIND_EVT, EV_UNBLOCK);
                        end
                    end else begin
                        st.lsga = st.lsga & ~DO_BIT;
                        if ((st.lsga & WILL_BIT) != 2'b00) begin
                            st.lsga = st.lsga & ~WILL_BIT;
                            lst = f_send3(lst, B_WONT, OPT_SGA);
                        end
                    end
                    if ((st.done & DONE_LSGA) != 3'b000) begin
                        st.done = st.done & ~DONE_LSGA;
                        lst = f_push(lst, KIND_EVT, EV_LSGA_DONE);
                    end
                end else if (is_do) begin
                    lst = f_send3(lst, B_WONT, i_byte);
                end
            end
            M_CR: begin
                // drop the byte that follows CR
                st.mode = M_DATA;
            end
            M_ESC: begin
                if (i_byte == CH_LBR) begin
                    st.mode = M_CSI;
                end else begin
                    st.mode = M_DATA;
                    lst = f_push(lst, KIND_EVT, (i_byte == CH_FF) ? EV_REDRAW : EV_BELL);
                end
            end
            M_CSI: begin
                st.mode = M_DATA;
                unique case (i_byte)
                    CH_A:    lst = f_push(lst, KIND_EVT, EV_UP);
                    CH_B:    lst = f_push(lst, KIND_EVT, EV_DOWN);
                    CH_C:    lst = f_push(lst, KIND_EVT, EV_RIGHT);
                    CH_D:    lst = f_push(lst, KIND_EVT, EV_LEFT);
                    default: lst = f_push(lst, KIND_EVT, EV_BELL);
                endcase
            end
            default: begin
                // plain data, unused modes included
                if (i_byte == B_IAC) begin
                    st.mode = M_IAC;
                end else if (i_byte == CH_ESC) begin
                    st.mode = M_ESC;
                end else if (i_byte == CH_CSI) begin
                    st.mode = M_CSI;
                end else begin
                    st.mode = (i_byte == CH_CR) ? M_CR : M_DATA;
                    lst = f_push(lst, KIND_DATA, i_byte);
                    if ((i_byte == CH_CR || i_byte == CH_LF) &&
                        (st.lsga != 2'b00 || st.rsga != 2'b00)) begin
                        lst = f_push(lst, KIND_EVT, EV_UNBLOCK);
                    end
                end
            end
        endcase

        o_state = st;
        o_list  = lst;
    end

endmodule

/* hw/rtl/tnr_queue.sv */
// Result queue: takes up to a full result list per cycle, hands out one beat per cycle while i_ready.
module tnr_queue #(
    parameter int DEPTH = tnr_pkg::Q_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [tnr_pkg::RES_CW-1:0]       i_push_n,
    input  tnr_pkg::t_entry_set              i_push_data,
    output logic [$clog2(DEPTH+1)-1:0]       o_free,
    output logic                             o_valid,
    input  logic                             i_ready,
    output tnr_pkg::t_entry                  o_data
);
    import tnr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            pop;

    assign pop     = o_valid & i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_free  = CW'(DEPTH) - r_count;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (RES_CW'(k) < i_push_n) r_mem[r_wr + AW'(k)] <= i_push_data[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + AW'(i_push_n);
            r_rd    <= r_rd + AW'(pop);
            r_count <= r_count + CW'(i_push_n) - CW'(pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue count beyond depth");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(i_push_n) <= o_free)
        else $error("result list pushed without room");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != CW'(DEPTH)) |-> (AW'(r_wr - r_rd) == AW'(r_count)))
        else $error("queue pointers disagree with count");

endmodule

/* hw/rtl/telnet_receive_negotiator.sv */
// Telnet receive negotiator: input register, state registers, per-byte decode, result queue.
// A taken byte is held in the input register and decoded; its results are written to the result queue.
// Throughput: one received byte per cycle while the queue has room for that byte's results;
// results leave at one beat per cycle while m_axis_tready is high, so bytes with up to eight
// results are absorbed by the QUEUE_DEPTH-entry queue and stall input only when room runs short.
// Reset (synchronous, active low): data mode, WILL ECHO, WILL SGA, DO SGA, two marks pending.
module telnet_receive_negotiator #(
    parameter int QUEUE_DEPTH = tnr_pkg::Q_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload, [8] echo_active,
                                        // [9] go_ahead_suppressed, [10] ack_enabled, 0s above
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last result of its byte
);
    import tnr_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    t_state            r_state;
    t_state            n_state;
    t_res_list         list;
    t_entry_set        push_data;
    t_entry            head;
    logic [CW-1:0]     free;
    logic [RES_CW-1:0] push_n;
    logic              room;
    logic              fire;

    tnr_decode u_decode (
        .i_byte  (r_in_byte),
        .i_state (r_state),
        .o_state (n_state),
        .o_list  (list)
    );

    assign room          = (CW'(list.cnt) <= free);
    assign fire          = r_in_valid & room;
    assign s_axis_tready = ~r_in_valid | room;
    assign push_n        = fire ? list.cnt : '0;

    always_comb begin
        for (int k = 0; k < MAX_RES; k++) begin
            push_data[k].kind                = list.kind[k];
            push_data[k].payload             = list.pay[k];
            push_data[k].last                = (RES_CW'(k + 1) == list.cnt);
            push_data[k].echo_active         = (n_state.echo == (WILL_BIT | DO_BIT));
            push_data[k].go_ahead_suppressed = (n_state.lsga != 2'b00) ||
                                               (n_state.rsga != 2'b00);
            push_data[k].ack_enabled         = n_state.ack_on;
        end
    end

    tnr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_n    (push_n),
        .i_push_data (push_data),
        .o_free      (free),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (head)
    );

    assign m_axis_tdata = {5'b0, head.ack_enabled, head.go_ahead_suppressed,
                           head.echo_active, head.payload};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_in_byte <= s_axis_tdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '{mode: M_DATA, echo: WILL_BIT, lsga: WILL_BIT, rsga: DO_BIT,
                            marks: 2'd2, ack_on: 1'b0, done: 3'b111};
        end else begin
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            if (fire) r_state <= n_state;
        end
    end

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_state))
        else $error("negotiation state changed without a processed byte");

    a_byte_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("pending byte lost before processing");

endmodule

/* verif/telnet_receive_negotiator_tb.sv */
// Self-checking testbench for the telnet receive negotiator: byte stream in, result beats out.
`timescale 1ns / 100ps

module telnet_receive_negotiator_tb;
    import tnr_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int STREAM_BYTES  = 380;
    localparam int QUIET_FROM    = 320;
    localparam int MAX_REPORTS   = 40;
    localparam int DRAIN_CYCLES  = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // [7:0] payload, [8] echo_active,
                                  // [9] go_ahead_suppressed, [10] ack_enabled, 0s above
    logic [1:0]  m_axis_tuser;    // [1:0] kind
    logic        m_axis_tlast;

    telnet_receive_negotiator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Negotiator state as predicted
    logic [3:0] rx_mode;
    logic [1:0] echo_st;
    logic [1:0] lsga_st;
    logic [1:0] rsga_st;
    logic [1:0] marks_left;
    logic       ack_on_st;
    logic [2:0] done_left;

    t_entry byte_results[$];
    t_entry expected_beats[$];

    int  error_count  = 0;
    int  bytes_sent   = 0;
    int  beats_checked = 0;
    int  cycle_count  = 0;
    bit  quiet        = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats still expected",
                     cycle_count, expected_beats.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    task automatic note(input logic [1:0] k, input logic [7:0] p);
        t_entry e;
        e = '0;
        e.kind    = k;
        e.payload = p;
        if (byte_results.size() < MAX_RES)
            byte_results.push_back(e);
    endtask

    task automatic reply3(input logic [7:0] cmd, input logic [7:0] opt);
        note(KIND_CMD, B_IAC);
        note(KIND_CMD, cmd);
        note(KIND_CMD, opt);
    endtask

    task automatic mark_done(input logic [2:0] flag, input logic [7:0] code);
        if ((done_left & flag) != 3'b000) begin
            done_left = done_left & ~flag;
            note(KIND_EVT, code);
        end
    endtask

    // WILL / WONT from the peer
    task automatic peer_option(input bit will, input logic [7:0] opt);
        if (opt == OPT_SGA) begin
            if (will) begin
                rsga_st = rsga_st | WILL_BIT;
                if ((rsga_st & DO_BIT) == 2'b00) begin
                    rsga_st = rsga_st | DO_BIT;
                    reply3(B_DO, OPT_SGA);
                    if (lsga_st == 2'b00) begin
                        reply3(B_WILL, OPT_SGA);
                        lsga_st = lsga_st | WILL_BIT;
                    end
                    note(KIND_EVT, EV_UNBLOCK);
                end
            end else begin
                rsga_st = rsga_st & ~WILL_BIT;
                if ((rsga_st & DO_BIT) != 2'b00) begin
                    rsga_st = rsga_st & ~DO_BIT;
                    reply3(B_DONT, OPT_SGA);
                end
            end
            mark_done(DONE_RSGA, EV_RSGA_DONE);
        end else if (opt == OPT_TM) begin
            if (marks_left != 2'd0)
                marks_left = marks_left - 2'd1;
            if (ack_on_st)
                note(KIND_EVT, EV_ACK);
            else if (echo_st == WILL_BIT && marks_left == 2'd0)
                ack_on_st = 1'b1;
        end else if (will) begin
            reply3(B_DONT, opt);
        end
    endtask

    // DO / DONT from the peer
    task automatic own_option(input bit doit, input logic [7:0] opt);
        if (opt == OPT_ECHO) begin
            if (doit) begin
                echo_st = echo_st | DO_BIT;
                if ((echo_st & WILL_BIT) == 2'b00) begin
                    echo_st = echo_st | WILL_BIT;
                    reply3(B_WILL, OPT_ECHO);
                end
            end else begin
                echo_st = echo_st & ~DO_BIT;
                if ((echo_st & WILL_BIT) != 2'b00) begin
                    echo_st = echo_st & ~WILL_BIT;
                    reply3(B_WONT, OPT_ECHO);
                end
            end
            mark_done(DONE_ECHO, EV_ECHO_DONE);
        end else if (opt == OPT_SGA) begin
            if (doit) begin
                lsga_st = lsga_st | DO_BIT;
                if ((lsga_st & WILL_BIT) == 2'b00) begin
                    lsga_st = lsga_st | WILL_BIT;
                    reply3(B_WILL, OPT_SGA);
                    if (rsga_st == 2'b00) begin
                        reply3(B_DO, OPT_SGA);
                        rsga_st = rsga_st | DO_BIT;
                    end
                    note(KIND_EVT, EV_UNBLOCK);
                end
            end else begin
                lsga_st = lsga_st & ~DO_BIT;
                if ((lsga_st & WILL_BIT) != 2'b00) begin
                    lsga_st = lsga_st & ~WILL_BIT;
                    reply3(B_WONT, OPT_SGA);
                end
            end
            mark_done(DONE_LSGA, EV_LSGA_DONE);
        end else if (doit) begin
            reply3(B_WONT, opt);
        end
    endtask

    task automatic iac_command(input logic [7:0] b);
        rx_mode = M_DATA;
        case (b)
            B_AO:    note(KIND_EVT, EV_ABORT);
            B_AYT:   note(KIND_EVT, EV_AYT);
            B_EC:    note(KIND_EVT, EV_ERASE_CHAR);
            B_EL:    note(KIND_EVT, EV_ERASE_LINE);
            B_GA:    note(KIND_EVT, EV_UNBLOCK);
            B_WILL:  rx_mode = M_WILL;
            B_WONT:  rx_mode = M_WONT;
            B_DO:    rx_mode = M_DO;
            B_DONT:  rx_mode = M_DONT;
            B_IAC:   note(KIND_DATA, B_IAC);
            default: ;
        endcase
    endtask

    task automatic plain_byte(input logic [7:0] b);
        if (b == B_IAC) begin
            rx_mode = M_IAC;
        end else if (b == CH_ESC) begin
            rx_mode = M_ESC;
        end else if (b == CH_CSI) begin
            rx_mode = M_CSI;
        end else begin
            rx_mode = M_DATA;
            note(KIND_DATA, b);
            if (b == CH_CR || b == CH_LF) begin
                if (b == CH_CR)
                    rx_mode = M_CR;
                if (lsga_st != 2'b00 || rsga_st != 2'b00)
                    note(KIND_EVT, EV_UNBLOCK);
            end
        end
    endtask

    // Advance the predicted state by one received byte and queue its result beats.
    task automatic predict_rx_byte(input logic [7:0] b);
        t_entry e;
        int     k;
        byte_results.delete();
        case (rx_mode)
            M_IAC:  iac_command(b);
            M_WILL: begin peer_option(1'b1, b); rx_mode = M_DATA; end
            M_WONT: begin peer_option(1'b0, b); rx_mode = M_DATA; end
            M_DO:   begin own_option(1'b1, b);  rx_mode = M_DATA; end
            M_DONT: begin own_option(1'b0, b);  rx_mode = M_DATA; end
            M_CR:   rx_mode = M_DATA;
            M_ESC: begin
                if (b == CH_LBR) begin
                    rx_mode = M_CSI;
                end else begin
                    note(KIND_EVT, (b == CH_FF) ? EV_REDRAW : EV_BELL);
                    rx_mode = M_DATA;
                end
            end
            M_CSI: begin
                case (b)
                    CH_A:    note(KIND_EVT, EV_UP);
                    CH_B:    note(KIND_EVT, EV_DOWN);
                    CH_C:    note(KIND_EVT, EV_RIGHT);
                    CH_D:    note(KIND_EVT, EV_LEFT);
                    default: note(KIND_EVT, EV_BELL);
                endcase
                rx_mode = M_DATA;
            end
            default: plain_byte(b);
        endcase
        // status fields reflect the state after the whole byte
        for (k = 0; k < byte_results.size(); k++) begin
            e = byte_results[k];
            e.last                = (k == byte_results.size() - 1);
            e.echo_active         = (echo_st == 2'b11);
            e.go_ahead_suppressed = (lsga_st != 2'b00 || rsga_st != 2'b00);
            e.ack_enabled         = ack_on_st;
            expected_beats.push_back(e);
        end
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic send_rx_byte(input logic [7:0] b);
        bit took;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        // sample tready mid-cycle, where it holds the value seen at the next edge
        do begin
            @(negedge i_clk);
            took = s_axis_tready;
            @(posedge i_clk);
        end while (!took);
        predict_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_iac3(input logic [7:0] cmd, input logic [7:0] opt);
        send_rx_byte(B_IAC);
        send_rx_byte(cmd);
        send_rx_byte(opt);
    endtask

    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic compare_field(input string what, input int want, input int got);
        if (want != got) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
        end
    endtask

    // beat moves at the next edge; inputs and outputs are stable at the falling edge
    always @(negedge i_clk) begin : check_results
        t_entry want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_beats.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t ns: extra beat, expected none, tuser=%0d tdata=%h tlast=%b",
                             $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end else begin
                want = expected_beats.pop_front();
                compare_field("kind", want.kind, m_axis_tuser);
                compare_field("payload", want.payload, m_axis_tdata[7:0]);
                compare_field("last", want.last, m_axis_tlast);
                compare_field("echo_active", want.echo_active, m_axis_tdata[8]);
                compare_field("go_ahead_suppressed", want.go_ahead_suppressed,
                              m_axis_tdata[9]);
                compare_field("ack_enabled", want.ack_enabled, m_axis_tdata[10]);
                compare_field("tdata padding", 0, m_axis_tdata[15:11]);
                beats_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Two replies bring the count to zero while ECHO is only offered, so
    // acknowledgements turn on; a third reply saturates and acknowledges.
    task automatic test_timing_marks();
        send_iac3(B_WILL, OPT_TM);
        send_iac3(B_WONT, OPT_TM);
        send_iac3(B_WILL, OPT_TM);
    endtask

    // A zero data byte, line ends and the byte swallowed after CR.
    task automatic test_line_ends();
        send_rx_byte(8'h00);
        send_rx_byte(CH_CR);
        send_rx_byte(B_IAC);
        send_rx_byte(CH_LF);
    endtask

    task automatic test_iac_commands();
        send_rx_byte(B_IAC);
        send_rx_byte(B_IAC);
        send_rx_byte(B_IAC);
        send_rx_byte(8'hF1);
    endtask

    task automatic test_unknown_options();
        send_iac3(B_WILL, 8'h18);
        send_iac3(B_DO, 8'hFF);
    endtask

    task automatic test_escape_keys();
        send_rx_byte(CH_ESC);
        send_rx_byte(8'h78);
        send_rx_byte(CH_CSI);
        send_rx_byte(8'h7A);
    endtask

    task automatic send_negotiation();
        logic [7:0] cmd;
        logic [7:0] opt;
        case ($urandom_range(0, 3))
            0:       cmd = B_WILL;
            1:       cmd = B_WONT;
            2:       cmd = B_DO;
            default: cmd = B_DONT;
        endcase
        case ($urandom_range(0, 4))
            0, 1:    opt = OPT_SGA;
            2:       opt = OPT_ECHO;
            3:       opt = OPT_TM;
            default: opt = 8'($urandom_range(0, 255));
        endcase
        send_iac3(cmd, opt);
    endtask

    task automatic send_csi_final();
        case ($urandom_range(0, 4))
            0:       send_rx_byte(CH_A);
            1:       send_rx_byte(CH_B);
            2:       send_rx_byte(CH_C);
            3:       send_rx_byte(CH_D);
            default: send_rx_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    // Mostly well-formed command and escape sequences with random content,
    // mixed with text lines, stray bytes and truncated prefixes.
    task automatic test_random_stream();
        int n;
        while (bytes_sent < STREAM_BYTES) begin
            if (bytes_sent >= QUIET_FROM)
                quiet = 1'b1;
            case ($urandom_range(0, 9))
                0, 1: send_rx_byte(8'($urandom_range(0, 255)));
                2: begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_rx_byte(8'($urandom_range(8'h20, 8'h7E)));
                    if ($urandom_range(0, 1)) begin
                        send_rx_byte(CH_CR);
                        send_rx_byte(8'($urandom_range(0, 255)));
                    end else begin
                        send_rx_byte(CH_LF);
                    end
                end
                3: begin
                    send_rx_byte(B_IAC);
                    case ($urandom_range(0, 6))
                        0:       send_rx_byte(B_AO);
                        1:       send_rx_byte(B_AYT);
                        2:       send_rx_byte(B_EC);
                        3:       send_rx_byte(B_EL);
                        4:       send_rx_byte(B_GA);
                        5:       send_rx_byte(B_IAC);
                        default: send_rx_byte(8'($urandom_range(0, 255)));
                    endcase
                end
                4, 5, 6: send_negotiation();
                7: begin
                    send_rx_byte(CH_ESC);
                    case ($urandom_range(0, 2))
                        0: begin
                            send_rx_byte(CH_LBR);
                            send_csi_final();
                        end
                        1:       send_rx_byte(CH_FF);
                        default: send_rx_byte(8'($urandom_range(0, 255)));
                    endcase
                end
                8: begin
                    send_rx_byte(CH_CSI);
                    send_csi_final();
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0:       send_rx_byte(B_IAC);
                        1:       send_rx_byte(CH_ESC);
                        2:       send_rx_byte(CH_CSI);
                        default: send_rx_byte(CH_CR);
                    endcase
                    send_rx_byte(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    initial begin
        rx_mode    = M_DATA;
        echo_st    = WILL_BIT;
        lsga_st    = WILL_BIT;
        rsga_st    = DO_BIT;
        marks_left = 2'd2;
        ack_on_st  = 1'b0;
        done_left  = DONE_ECHO | DONE_LSGA | DONE_RSGA;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        m_axis_tready <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_timing_marks();
        test_line_ends();
        test_iac_commands();
        test_unknown_options();
        test_escape_keys();
        test_random_stream();
        s_axis_tvalid <= 1'b0;

        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d received bytes, checked %0d result beats.", bytes_sent, beats_checked);
        $display("Stream mixed text lines, IAC commands, option negotiation, timing marks and keys.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/tnr_pkg.sv
hw/rtl/tnr_decode.sv
hw/rtl/tnr_queue.sv
hw/rtl/telnet_receive_negotiator.sv
verif/telnet_receive_negotiator_tb.sv
